[hw/rtl/mscs_pkg.sv]
// ----------------------------------------------------------------------------
// mscs_pkg
// Shared types, constants and operand setup for the marching squares
// cell segment core.
// ----------------------------------------------------------------------------
package mscs_pkg;

    localparam int W        = 32;          // value width, signed Q16.16
    localparam int NDIV     = W;           // quotient bits, one per divide stage
    localparam int LANE_ST  = NDIV + 2;    // multiply, divide steps, final add
    localparam int NST      = LANE_ST + 2; // input stage, setup stage, lane
    localparam int IN_BITS  = 8 * W;
    localparam int OUT_BITS = 4 * W;

    // reduced case codes (complement folded onto the low half)
    localparam logic [3:0] K_UR    = 4'd1;
    localparam logic [3:0] K_LR    = 4'd2;
    localparam logic [3:0] K_RIGHT = 4'd3;
    localparam logic [3:0] K_LL    = 4'd4;
    localparam logic [3:0] K_LOWER = 4'd6;
    localparam logic [3:0] K_UL    = 4'd7;

    // full case codes that never give a segment
    localparam logic [3:0] CODE_EMPTY     = 4'b0000;
    localparam logic [3:0] CODE_FULL      = 4'b1111;
    localparam logic [3:0] CODE_SADDLE_LL = 4'b0101;
    localparam logic [3:0] CODE_SADDLE_UL = 4'b1010;

    // operands of one edge interpolation
    typedef struct packed {
        logic [W-1:0] p0;
        logic [W-1:0] a;
        logic [W-1:0] b;
        logic [W-1:0] c;
        logic         neg;
        logic         bypass;
    } lane_op_t;

    // per cell sideband that runs beside the lanes
    typedef struct packed {
        logic [3:0]   code;
        logic         seg;
        logic         start_fix_x;  // start x is the fixed coordinate
        logic         end_fix_x;    // end x is the fixed coordinate
        logic [W-1:0] start_fix;
        logic [W-1:0] end_fix;
    } side_t;

    // magnitudes and signs for z = p0 - f0 * (p1 - p0) / (f1 - f0)
    function automatic lane_op_t make_ops(input logic signed [W-1:0] p0,
                                          input logic signed [W-1:0] p1,
                                          input logic signed [W-1:0] f0,
                                          input logic signed [W-1:0] f1);
        logic signed [W:0] dp;
        logic signed [W:0] df;
        logic [W:0]        a_w;
        logic [W:0]        b_w;
        logic [W:0]        c_w;
        lane_op_t          r;
        dp  = {p1[W-1], p1} - {p0[W-1], p0};
        df  = {f1[W-1], f1} - {f0[W-1], f0};
        a_w = f0[W-1] ? -{f0[W-1], f0} : {f0[W-1], f0};
        b_w = dp[W] ? -dp : dp;
        c_w = df[W] ? -df : df;
        r.p0     = p0;
        r.a      = a_w[W-1:0];
        r.b      = b_w[W-1:0];
        r.c      = c_w[W-1:0];
        r.neg    = f0[W-1] ^ dp[W] ^ df[W];
        r.bypass = (c_w == '0) || (a_w > c_w);
        return r;
    endfunction

endpackage

[hw/rtl/marching_squares_cell_segment_core.sv]
// ----------------------------------------------------------------------------
// marching_squares_cell_segment_core
// Classifies one cell by corner signs and gives at most one interpolated
// zero-contour segment.
//
//  channel | dir | tdata                                   | tuser
//  s_      | in  | ul, ll, lr, ur phi, left_x, right_x,    | -
//          |     | top_y, bottom_y (32 bits each)          |
//  m_      | out | start_x, start_y, end_x, end_y          | segment_valid, case_code
//
// pipeline: input register, operand setup, multiply, 32 divide
// stages (one quotient bit each), final add into the output register
// one cell per cycle sustained while m_tready is high; each stage holds only
// while the one after it is full and stalled, so bubbles are squeezed out under backpressure
// reset clears the stage valid bits only
// ----------------------------------------------------------------------------
module marching_squares_cell_segment_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // phi_upper_left, phi_lower_left, phi_lower_right, phi_upper_right,
    // left_x, right_x, top_y, bottom_y
    input  logic [mscs_pkg::IN_BITS-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // start_x, start_y, end_x, end_y
    output logic [mscs_pkg::OUT_BITS-1:0] m_tdata,
    // segment_valid, case_code[3:0]
    output logic [4:0]                    m_tuser
);

    localparam int W   = mscs_pkg::W;
    localparam int NST = mscs_pkg::NST;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] v_next;
    logic [NST-1:0] rdy;

    logic [mscs_pkg::IN_BITS-1:0] in_reg;
    mscs_pkg::lane_op_t           sop_reg;
    mscs_pkg::lane_op_t           eop_reg;
    mscs_pkg::side_t              side_reg [1:NST-1];

    mscs_pkg::lane_op_t sop;
    mscs_pkg::lane_op_t eop;
    mscs_pkg::side_t    side;
    logic [W-1:0]       sz;
    logic [W-1:0]       ez;

    // stage enables: a stage loads when empty or when the next one moves
    always_comb
    begin
        rdy[NST-1] = !v_reg[NST-1] || m_tready;
        for (int i = NST - 2; i >= 0; i--)
            rdy[i] = !v_reg[i] || rdy[i+1];
    end

    always_comb
    begin
        v_next = v_reg;
        if (rdy[0])
            v_next[0] = s_tvalid;
        for (int i = 1; i < NST; i++)
            if (rdy[i])
                v_next[i] = v_reg[i-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (rdy[0])
            in_reg <= s_tdata;
    end

    // operand setup for both segment ends
    always_comb
    begin
        logic signed [W-1:0] ful, fll, flr, fur, lx, rx, ty, by;
        logic [3:0] code;
        logic [3:0] k;
        mscs_pkg::lane_op_t zero_op;
        ful = in_reg[0*W +: W];
        fll = in_reg[1*W +: W];
        flr = in_reg[2*W +: W];
        fur = in_reg[3*W +: W];
        lx  = in_reg[4*W +: W];
        rx  = in_reg[5*W +: W];
        ty  = in_reg[6*W +: W];
        by  = in_reg[7*W +: W];
        code = {ful[W-1], fll[W-1], flr[W-1], fur[W-1]};
        k    = code[3] ? ~code : code;
        zero_op = '{p0: '0, a: '0, b: '0, c: '0, neg: 1'b0, bypass: 1'b1};
        sop = zero_op;
        eop = zero_op;
        side = '{code: code, seg: 1'b1, start_fix_x: 1'b0, end_fix_x: 1'b1,
                 start_fix: '0, end_fix: '0};
        unique case (k)
            mscs_pkg::K_UR:
            begin
                sop = mscs_pkg::make_ops(rx, lx, fur, ful);
                eop = mscs_pkg::make_ops(by, ty, flr, fur);
                side.start_fix = ty;
                side.end_fix   = rx;
            end
            mscs_pkg::K_LR:
            begin
                sop = mscs_pkg::make_ops(lx, rx, fll, flr);
                eop = mscs_pkg::make_ops(ty, by, fur, flr);
                side.start_fix = by;
                side.end_fix   = rx;
            end
            mscs_pkg::K_RIGHT:
            begin
                sop = mscs_pkg::make_ops(rx, lx, fur, ful);
                eop = mscs_pkg::make_ops(lx, rx, fll, flr);
                side.start_fix = ty;
                side.end_fix_x = 1'b0;
                side.end_fix   = by;
            end
            mscs_pkg::K_LL:
            begin
                sop = mscs_pkg::make_ops(ty, by, ful, fll);
                eop = mscs_pkg::make_ops(lx, rx, fll, flr);
                side.start_fix_x = 1'b1;
                side.start_fix   = lx;
                side.end_fix_x   = 1'b0;
                side.end_fix     = by;
            end
            mscs_pkg::K_LOWER:
            begin
                sop = mscs_pkg::make_ops(ty, by, ful, fll);
                eop = mscs_pkg::make_ops(by, ty, flr, fur);
                side.start_fix_x = 1'b1;
                side.start_fix   = lx;
                side.end_fix     = rx;
            end
            mscs_pkg::K_UL:
            begin
                sop = mscs_pkg::make_ops(lx, rx, ful, fur);
                eop = mscs_pkg::make_ops(ty, by, ful, fll);
                side.start_fix = ty;
                side.end_fix   = lx;
            end
            default:
            begin
                // empty, full and saddle cells: all coordinates zero
                side.seg = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            sop_reg     <= sop;
            eop_reg     <= eop;
            side_reg[1] <= side;
        end
    end

    // sideband delay line beside the lanes
    for (genvar i = 2; i < NST; i++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (rdy[i])
                side_reg[i] <= side_reg[i-1];
        end
    end

    mscs_muldiv_lane u_start_lane
    (
        .clk (clk),
        .en  (rdy[NST-1:2]),
        .op  (sop_reg),
        .z   (sz)
    );

    mscs_muldiv_lane u_end_lane
    (
        .clk (clk),
        .en  (rdy[NST-1:2]),
        .op  (eop_reg),
        .z   (ez)
    );

    // output beat
    assign s_tready = rdy[0];
    assign m_tvalid = v_reg[NST-1];
    assign m_tuser  = {side_reg[NST-1].code, side_reg[NST-1].seg};
    assign m_tdata  = {
        side_reg[NST-1].end_fix_x   ? ez : side_reg[NST-1].end_fix,
        side_reg[NST-1].end_fix_x   ? side_reg[NST-1].end_fix : ez,
        side_reg[NST-1].start_fix_x ? sz : side_reg[NST-1].start_fix,
        side_reg[NST-1].start_fix_x ? side_reg[NST-1].start_fix : sz
    };

endmodule

[hw/rtl/mscs_muldiv_lane.sv]
// ----------------------------------------------------------------------------
// mscs_muldiv_lane
// Pipelined p0 +/- floor(a*b/c), or p0 alone when bypass is set: one multiply
// stage, one restoring divide stage per quotient bit, one add stage.
// ----------------------------------------------------------------------------
module mscs_muldiv_lane
(
    input  logic                              clk,
    input  logic [mscs_pkg::LANE_ST-1:0]      en,
    input  mscs_pkg::lane_op_t                op,
    output logic [mscs_pkg::W-1:0]            z
);

    localparam int W    = mscs_pkg::W;
    localparam int NDIV = mscs_pkg::NDIV;

    logic [W-1:0] rem_reg [0:NDIV];
    logic [W-1:0] lq_reg  [0:NDIV];
    logic [W-1:0] c_reg   [0:NDIV];
    logic [W-1:0] p0_reg  [0:NDIV];
    logic         neg_reg [0:NDIV];
    logic         byp_reg [0:NDIV];
    logic [W-1:0] z_reg;
    logic [2*W-1:0] prod;

    // multiply stage
    assign prod = op.a * op.b;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0] <= prod[2*W-1:W];
            lq_reg[0]  <= prod[W-1:0];
            c_reg[0]   <= op.c;
            p0_reg[0]  <= op.p0;
            neg_reg[0] <= op.neg;
            byp_reg[0] <= op.bypass;
        end
    end

    // one quotient bit per stage
    for (genvar i = 1; i <= NDIV; i++)
    begin : g_div
        logic [W:0] t;
        logic [W:0] d;
        logic       ge;
        assign t  = {rem_reg[i-1], lq_reg[i-1][W-1]};
        assign d  = t - {1'b0, c_reg[i-1]};
        assign ge = t >= {1'b0, c_reg[i-1]};
        always_ff @(posedge clk)
        begin
            if (en[i])
            begin
                rem_reg[i] <= ge ? d[W-1:0] : t[W-1:0];
                lq_reg[i]  <= {lq_reg[i-1][W-2:0], ge};
                c_reg[i]   <= c_reg[i-1];
                p0_reg[i]  <= p0_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
                byp_reg[i] <= byp_reg[i-1];
            end
        end
    end

    // final add
    always_ff @(posedge clk)
    begin
        if (en[NDIV+1])
        begin
            if (byp_reg[NDIV])
                z_reg <= p0_reg[NDIV];
            else if (neg_reg[NDIV])
                z_reg <= p0_reg[NDIV] + lq_reg[NDIV];
            else
                z_reg <= p0_reg[NDIV] - lq_reg[NDIV];
        end
    end

    assign z = z_reg;

endmodule

[hw/rtl/mscs_checker.sv]
// ----------------------------------------------------------------------------
// mscs_checker
// Port level checks for the marching squares cell segment core.
// ----------------------------------------------------------------------------
module mscs_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mscs_pkg::OUT_BITS-1:0] m_tdata,
    input logic [4:0]                    m_tuser
);

    // a stalled output beat stays
    a_hold_valid : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped while stalled");

    a_hold_data : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    // no segment means all coordinates zero
    a_zero_coords : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("coordinates not zero without a segment");

    // empty, full and saddle cells never give a segment
    a_no_seg_codes : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |->
            m_tuser[4:1] != mscs_pkg::CODE_EMPTY &&
            m_tuser[4:1] != mscs_pkg::CODE_FULL &&
            m_tuser[4:1] != mscs_pkg::CODE_SADDLE_LL &&
            m_tuser[4:1] != mscs_pkg::CODE_SADDLE_UL)
        else $error("segment on a cell that has none");

    // a free output side lets the whole pipeline move
    a_ready_flow : assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input held while output side is free");

    // input side is only watched through its handshake
    logic unused_in;
    assign unused_in = s_tvalid;

endmodule

bind marching_squares_cell_segment_core mscs_checker u_mscs_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
